@@ rtl/core/iws_pkg.sv @@
package iws_pkg;

	// field widths
	localparam int MinuteW  = 11;
	localparam int DurW     = 8;
	localparam int SecondW  = 6;
	localparam int RainW    = 12;
	localparam int TempW    = 11;
	localparam int StopW    = 18;
	localparam int GainW    = 16;
	localparam int CentreW  = 12;
	localparam int CfgAddrW = 3;
	localparam int CfgDataW = 16;
	localparam int PhaseW   = 2;

	// register map
	typedef enum logic [CfgAddrW-1:0] {
		REG_W0_START     = 3'd0,
		REG_W0_DURATION  = 3'd1,
		REG_W1_START     = 3'd2,
		REG_W1_DURATION  = 3'd3,
		REG_RAIN_GAINS   = 3'd4,
		REG_TEMP_GAINS   = 3'd5,
		REG_TEMP_CENTRES = 3'd6
	} cfg_reg_t;

	// temperature reading that means "no sensor data"
	localparam logic signed [TempW-1:0] TempNone = 11'sh400;
	// nominal stop saturates here
	localparam logic [MinuteW-1:0] StopMax = 11'h7FF;

	// phase codes as seen on the result port
	localparam logic [PhaseW-1:0] PhaseCodeInactive = 2'd0;
	localparam logic [PhaseW-1:0] PhaseCodeActive   = 2'd1;
	localparam logic [PhaseW-1:0] PhaseCodeFinished = 2'd2;

	typedef enum logic [2:0] {
		PH_INACTIVE = 3'b001,
		PH_ACTIVE   = 3'b010,
		PH_FINISHED = 3'b100
	} phase_t;

	typedef struct packed {
		logic [MinuteW-1:0] w0_start;
		logic [DurW-1:0]    w0_dur;
		logic [MinuteW-1:0] w1_start;
		logic [DurW-1:0]    w1_dur;
		logic [GainW-1:0]   rain_gains;
		logic [GainW-1:0]   temp_gains;
		logic [CentreW-1:0] temp_centres;
	} cfg_t;

	// window hit and the stops it would latch
	typedef struct packed {
		logic                     hit;
		logic                     win;
		logic [MinuteW-1:0]       nominal;
		logic signed [StopW-1:0]  corrected;
	} launch_t;

	// sequencer state after the current tick
	typedef struct packed {
		phase_t                   phase;
		logic                     changed;
		logic signed [StopW-1:0]  corrected;
		logic                     win;
		logic [RainW-1:0]         rain;
		logic signed [TempW-1:0]  temp;
	} seq_status_t;

	function automatic logic [PhaseW-1:0] phase_code(phase_t ph);
		logic [PhaseW-1:0] code;
		case (ph)
			PH_INACTIVE: code = PhaseCodeInactive;
			PH_ACTIVE:   code = PhaseCodeActive;
			default:     code = PhaseCodeFinished;
		endcase
		return code;
	endfunction

endpackage

@@ rtl/core/iws_cfg_regs.sv @@
module iws_cfg_regs
	import iws_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [CfgAddrW-1:0] cfg_addr,
	input  logic [CfgDataW-1:0] cfg_wdata,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	// register file, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_addr))
				REG_W0_START:     cfg_q.w0_start     <= cfg_wdata[MinuteW-1:0];
				REG_W0_DURATION:  cfg_q.w0_dur       <= cfg_wdata[DurW-1:0];
				REG_W1_START:     cfg_q.w1_start     <= cfg_wdata[MinuteW-1:0];
				REG_W1_DURATION:  cfg_q.w1_dur       <= cfg_wdata[DurW-1:0];
				REG_RAIN_GAINS:   cfg_q.rain_gains   <= cfg_wdata[GainW-1:0];
				REG_TEMP_GAINS:   cfg_q.temp_gains   <= cfg_wdata[GainW-1:0];
				REG_TEMP_CENTRES: cfg_q.temp_centres <= cfg_wdata[CentreW-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/core/iws_stop_calc.sv @@
module iws_stop_calc
	import iws_pkg::*;
(
	input  cfg_t                    cfg,
	input  logic [MinuteW-1:0]      minute,
	input  logic [RainW-1:0]        rain,
	input  logic signed [TempW-1:0] temp,
	output launch_t                 launch
);

	logic [MinuteW:0]          sum0, sum1;
	logic [MinuteW-1:0]        stop0, stop1, stop_sel;
	logic                      hit0, hit1, sel;
	logic [7:0]                rg, tg;
	logic [5:0]                centre;
	logic [19:0]               rain_term;
	logic signed [12:0]        temp_diff;
	logic signed [21:0]        temp_term, temp_use;
	logic signed [22:0]        corr_sum, corr_adj;
	logic signed [18:0]        corr_quot;
	logic signed [19:0]        stop_diff;

	// nominal stops, saturated to 11 bits
	assign sum0  = {1'b0, cfg.w0_start} + {{(MinuteW+1-DurW){1'b0}}, cfg.w0_dur};
	assign sum1  = {1'b0, cfg.w1_start} + {{(MinuteW+1-DurW){1'b0}}, cfg.w1_dur};
	assign stop0 = sum0[MinuteW] ? StopMax : sum0[MinuteW-1:0];
	assign stop1 = sum1[MinuteW] ? StopMax : sum1[MinuteW-1:0];

	// window hits, window 0 has priority
	assign hit0 = (cfg.w0_dur != '0) && (minute >= cfg.w0_start) && (minute <= stop0);
	assign hit1 = (cfg.w1_dur != '0) && (minute >= cfg.w1_start) && (minute <= stop1);
	assign sel  = !hit0;

	// per-window coefficients
	assign rg       = sel ? cfg.rain_gains[15:8]    : cfg.rain_gains[7:0];
	assign tg       = sel ? cfg.temp_gains[15:8]    : cfg.temp_gains[7:0];
	assign centre   = sel ? cfg.temp_centres[11:6]  : cfg.temp_centres[5:0];
	assign stop_sel = sel ? stop1 : stop0;

	// weather correction terms
	assign rain_term = 20'(rain) * 20'(rg);
	assign temp_diff = $signed({3'b000, centre, 4'b0000}) - 13'(temp);
	assign temp_term = 22'(temp_diff) * $signed({14'd0, tg});
	assign temp_use  = (temp != TempNone) ? temp_term : '0;
	assign corr_sum  = $signed({3'b000, rain_term}) + 23'(temp_use);

	// divide by 16 rounding toward zero
	assign corr_adj  = corr_sum + (corr_sum[22] ? 23'sd15 : 23'sd0);
	assign corr_quot = 19'(corr_adj >>> 4);
	assign stop_diff = $signed({9'd0, stop_sel}) - 20'(corr_quot);

	assign launch.hit       = hit0 | hit1;
	assign launch.win       = sel;
	assign launch.nominal   = stop_sel;
	assign launch.corrected = stop_diff[StopW-1:0];

endmodule

@@ rtl/core/iws_phase_seq.sv @@
module iws_phase_seq
	import iws_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    advance,
	input  logic [MinuteW-1:0]      minute,
	input  logic [RainW-1:0]        rain,
	input  logic signed [TempW-1:0] temp,
	input  launch_t                 launch,
	output seq_status_t             status
);

	phase_t                  phase_q, phase_d;
	logic [MinuteW-1:0]      nominal_q, nominal_d;
	logic signed [StopW-1:0] corrected_q, corrected_d;
	logic                    win_q, win_d;
	logic [RainW-1:0]        rain_q, rain_d;
	logic signed [TempW-1:0] temp_q, temp_d;
	logic signed [StopW:0]   minute_sx;

	// minute as a signed value for the corrected-stop compares
	assign minute_sx = $signed({{(StopW+1-MinuteW){1'b0}}, minute});

	// next state for this tick
	always_comb begin
		phase_d     = phase_q;
		nominal_d   = nominal_q;
		corrected_d = corrected_q;
		win_d       = win_q;
		rain_d      = rain_q;
		temp_d      = temp_q;
		case (phase_q)
			PH_INACTIVE: begin
				if (launch.hit) begin
					nominal_d   = launch.nominal;
					corrected_d = launch.corrected;
					win_d       = launch.win;
					rain_d      = rain;
					temp_d      = temp;
					phase_d     = (minute_sx < (StopW+1)'(launch.corrected)) ?
						PH_ACTIVE : PH_FINISHED;
				end
			end
			PH_ACTIVE: begin
				if (minute_sx >= (StopW+1)'(corrected_q))
					phase_d = (minute >= nominal_q) ? PH_INACTIVE : PH_FINISHED;
			end
			default: begin
				if (minute > nominal_q)
					phase_d = PH_INACTIVE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_INACTIVE;
			nominal_q   <= '0;
			corrected_q <= '0;
			win_q       <= 1'b0;
			rain_q      <= '0;
			temp_q      <= '0;
		end else if (advance) begin
			phase_q     <= phase_d;
			nominal_q   <= nominal_d;
			corrected_q <= corrected_d;
			win_q       <= win_d;
			rain_q      <= rain_d;
			temp_q      <= temp_d;
		end
	end

	assign status.phase     = phase_d;
	assign status.changed   = (phase_d != phase_q);
	assign status.corrected = corrected_d;
	assign status.win       = win_d;
	assign status.rain      = rain_d;
	assign status.temp      = temp_d;

endmodule

@@ rtl/core/irrigation_window_sequencer_unit.sv @@
// Irrigation window sequencer. Each input beat is one time tick; each tick yields exactly one
// result beat with the valve state, the phase after the tick, a phase-change flag, a refresh
// request on second zero and the stop, window and weather statistics latched at the last run
// start. A tick is registered in the input register, evaluated by the window match, the two
// small correction multipliers and the phase logic, and lands in the output register once
// that register is free or draining, which waits while a result is still held. One tick is
// taken every cycle while results are drained. While a result waits, the input register still
// takes one more tick, after which in_ready drops until out_ready returns. The user must write
// registers through the cfg port only while no tick is in flight; the block does not enforce
// this. Unknown indexes are ignored.
module irrigation_window_sequencer_unit
	import iws_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [CfgAddrW-1:0]      cfg_addr,
	input  logic [CfgDataW-1:0]      cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [MinuteW-1:0]       minute_of_day,
	input  logic [SecondW-1:0]       second_now,
	input  logic [RainW-1:0]         rain_stat,
	input  logic signed [TempW-1:0]  temp_stat,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     valve_on,
	output logic                     force_refresh,
	output logic [PhaseW-1:0]        phase,
	output logic                     phase_changed,
	output logic signed [StopW-1:0]  real_stop,
	output logic                     window_used,
	output logic [RainW-1:0]         used_rain,
	output logic signed [TempW-1:0]  used_temp
);

	cfg_t                    cfg;
	launch_t                 launch;
	seq_status_t             status;
	logic                    valid_s1;
	logic [MinuteW-1:0]      minute_s1;
	logic [SecondW-1:0]      second_s1;
	logic [RainW-1:0]        rain_s1;
	logic signed [TempW-1:0] temp_s1;
	logic                    advance;
	logic                    out_valid_q;
	logic                    valve_on_q, refresh_q, changed_q, window_q;
	logic [PhaseW-1:0]       phase_q;
	logic signed [StopW-1:0] stop_q;
	logic [RainW-1:0]        rain_q;
	logic signed [TempW-1:0] temp_q;

	iws_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// handshake: stage 1 moves on when the output register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			minute_s1 <= minute_of_day;
			second_s1 <= second_now;
			rain_s1   <= rain_stat;
			temp_s1   <= temp_stat;
		end
	end

	iws_stop_calc u_calc (
		.cfg    (cfg),
		.minute (minute_s1),
		.rain   (rain_s1),
		.temp   (temp_s1),
		.launch (launch)
	);

	iws_phase_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.minute  (minute_s1),
		.rain    (rain_s1),
		.temp    (temp_s1),
		.launch  (launch),
		.status  (status)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			valve_on_q <= (status.phase == PH_ACTIVE);
			refresh_q  <= (second_s1 == '0);
			phase_q    <= phase_code(status.phase);
			changed_q  <= status.changed;
			stop_q     <= status.corrected;
			window_q   <= status.win;
			rain_q     <= status.rain;
			temp_q     <= status.temp;
		end
	end

	assign out_valid     = out_valid_q;
	assign valve_on      = valve_on_q;
	assign force_refresh = refresh_q;
	assign phase         = phase_q;
	assign phase_changed = changed_q;
	assign real_stop     = stop_q;
	assign window_used   = window_q;
	assign used_rain     = rain_q;
	assign used_temp     = temp_q;

endmodule

@@ dv/tb_irrigation_window_sequencer_unit.sv @@
module tb_irrigation_window_sequencer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import iws_pkg::*;

	// index with no register behind it
	localparam logic [CfgAddrW-1:0] RegSpare = 3'd7;
	localparam int IdlePct    = 22;
	localparam int PhaseItems = 225;
	localparam int HoldCycles = 160;

	typedef struct packed {
		logic [MinuteW-1:0]      minute;
		logic [SecondW-1:0]      second;
		logic [RainW-1:0]        rain;
		logic signed [TempW-1:0] temp;
	} tick_t;

	typedef struct packed {
		logic                    valve;
		logic                    refresh;
		logic [PhaseW-1:0]       ph;
		logic                    changed;
		logic signed [StopW-1:0] stop;
		logic                    win;
		logic [RainW-1:0]        rain;
		logic signed [TempW-1:0] temp;
	} status_t;

	// Tracks the sequencer phase and latches, queues the status each tick should produce
	class sequencer_board;
		logic [MinuteW-1:0]      start_min [2];
		logic [DurW-1:0]         dur [2];
		logic [GainW-1:0]        rain_g;
		logic [GainW-1:0]        temp_g;
		logic [CentreW-1:0]      centres;
		logic [PhaseW-1:0]       ph;
		logic [MinuteW-1:0]      nominal;
		logic signed [StopW-1:0] corrected;
		logic                    win;
		logic [RainW-1:0]        rain_held;
		logic signed [TempW-1:0] temp_held;
		status_t                 expected_q [$];
		int unsigned             errors;

		function new();
			start_min[0] = '0;
			start_min[1] = '0;
			dur[0] = '0;
			dur[1] = '0;
			rain_g = '0;
			temp_g = '0;
			centres = '0;
			ph = PhaseCodeInactive;
			nominal = '0;
			corrected = '0;
			win = 1'b0;
			rain_held = '0;
			temp_held = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] data);
			case (addr)
				REG_W0_START:     start_min[0] = data[MinuteW-1:0];
				REG_W0_DURATION:  dur[0] = data[DurW-1:0];
				REG_W1_START:     start_min[1] = data[MinuteW-1:0];
				REG_W1_DURATION:  dur[1] = data[DurW-1:0];
				REG_RAIN_GAINS:   rain_g = data[GainW-1:0];
				REG_TEMP_GAINS:   temp_g = data[GainW-1:0];
				REG_TEMP_CENTRES: centres = data[CentreW-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_tick(tick_t t);
			logic [PhaseW-1:0] old_ph;
			logic [PhaseW-1:0] next_ph;
			bit                launched;
			int                stop_min;
			int                weather;
			int                corr;
			int                rg;
			int                tg;
			int                centre;
			int                minute_val;
			int                temp_val;
			status_t           s;
			old_ph = ph;
			next_ph = ph;
			minute_val = t.minute;
			temp_val = $signed(t.temp);
			launched = 1'b0;
			case (ph)
				PhaseCodeInactive: begin
					// first enabled window containing the minute starts a run
					for (int w = 0; w < 2; w++) begin
						stop_min = start_min[w] + dur[w];
						if (stop_min > StopMax)
							stop_min = StopMax;
						if (!launched && dur[w] != 0 && minute_val >= start_min[w] &&
								minute_val <= stop_min) begin
							rg = rain_g[8*w +: 8];
							tg = temp_g[8*w +: 8];
							centre = centres[6*w +: 6];
							weather = int'(t.rain) * rg;
							if (t.temp != TempNone)
								weather += (centre * 16 - temp_val) * tg;
							// integer divide truncates toward zero
							corr = stop_min - weather / 16;
							nominal = MinuteW'(stop_min);
							corrected = StopW'(corr);
							win = w[0];
							rain_held = t.rain;
							temp_held = t.temp;
							next_ph = (minute_val < corr) ? PhaseCodeActive : PhaseCodeFinished;
							launched = 1'b1;
						end
					end
				end
				PhaseCodeActive: begin
					if (minute_val >= corrected)
						next_ph = (t.minute >= nominal) ? PhaseCodeInactive : PhaseCodeFinished;
				end
				default: begin
					if (t.minute > nominal)
						next_ph = PhaseCodeInactive;
				end
			endcase
			ph = next_ph;
			s.valve = (ph == PhaseCodeActive);
			s.refresh = (t.second == 0);
			s.ph = ph;
			s.changed = (ph != old_ph);
			s.stop = corrected;
			s.win = win;
			s.rain = rain_held;
			s.temp = temp_held;
			expected_q.push_back(s);
		endfunction

		function void compare_field(string name, logic signed [31:0] want,
				logic signed [31:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(status_t got);
			status_t want;
			if (expected_q.size() == 0) begin
				$error("result beat with no tick outstanding");
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("valve_on", want.valve, got.valve);
			compare_field("force_refresh", want.refresh, got.refresh);
			compare_field("phase", want.ph, got.ph);
			compare_field("phase_changed", want.changed, got.changed);
			compare_field("real_stop", $signed(want.stop), $signed(got.stop));
			compare_field("window_used", want.win, got.win);
			compare_field("used_rain", want.rain, got.rain);
			compare_field("used_temp", $signed(want.temp), $signed(got.temp));
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_wr_en = 1'b0;
	logic [CfgAddrW-1:0]     cfg_addr = '0;
	logic [CfgDataW-1:0]     cfg_wdata = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [MinuteW-1:0]      minute_of_day = '0;
	logic [SecondW-1:0]      second_now = '0;
	logic [RainW-1:0]        rain_stat = '0;
	logic signed [TempW-1:0] temp_stat = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic                    valve_on;
	logic                    force_refresh;
	logic [PhaseW-1:0]       phase;
	logic                    phase_changed;
	logic signed [StopW-1:0] real_stop;
	logic                    window_used;
	logic [RainW-1:0]        used_rain;
	logic signed [TempW-1:0] used_temp;

	sequencer_board board;
	int unsigned    ticks_sent = 0;
	int unsigned    phase_goal = 0;
	int unsigned    results_seen = 0;
	int unsigned    hold_left = 0;
	status_t        beat_seen;
	logic [MinuteW-1:0] win_start [2];
	logic [DurW-1:0]    win_len [2];

	irrigation_window_sequencer_unit dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	// result side: check each beat, random ready with one quiet stretch and long holds
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				beat_seen.valve = valve_on;
				beat_seen.refresh = force_refresh;
				beat_seen.ph = phase;
				beat_seen.changed = phase_changed;
				beat_seen.stop = real_stop;
				beat_seen.win = window_used;
				beat_seen.rain = used_rain;
				beat_seen.temp = used_temp;
				board.check_result(beat_seen);
				results_seen++;
				if (results_seen == 400 || results_seen == 1100)
					hold_left = HoldCycles;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (results_seen >= 600 && results_seen < 900) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= IdlePct);
			end
		end
	end

	function automatic tick_t make_tick(int minute, int second, int rain, int temp);
		tick_t t;
		t.minute = MinuteW'(minute);
		t.second = SecondW'(second);
		t.rain = RainW'(rain);
		t.temp = TempW'(temp);
		return t;
	endfunction

	// start minute in range, junk above the register width
	function automatic logic [CfgDataW-1:0] start_word();
		return CfgDataW'($urandom_range(0, 1439) | ($urandom_range(0, 31) << MinuteW));
	endfunction

	task automatic offer_tick(tick_t t);
		// random gaps on the input, except through the calm stretch
		if (ticks_sent < 700 || ticks_sent >= 1000) begin
			while ($urandom_range(99) < IdlePct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		minute_of_day <= t.minute;
		second_now <= t.second;
		rain_stat <= t.rain;
		temp_stat <= t.temp;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_tick(t);
		ticks_sent++;
	endtask

	// stop offering and wait out every outstanding result
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_reg(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		board.write_reg(addr, data);
	endtask

	task automatic program_windows(input logic [CfgDataW-1:0] s0, d0, s1, d1, rg, tg, tc);
		drain();
		set_reg(REG_W0_START, s0);
		set_reg(REG_W0_DURATION, d0);
		set_reg(REG_W1_START, s1);
		set_reg(REG_W1_DURATION, d1);
		set_reg(REG_RAIN_GAINS, rg);
		set_reg(REG_TEMP_GAINS, tg);
		set_reg(REG_TEMP_CENTRES, tc);
		cfg_wr_en <= 1'b0;
		win_start[0] = s0[MinuteW-1:0];
		win_len[0] = d0[DurW-1:0];
		win_start[1] = s1[MinuteW-1:0];
		win_len[1] = d1[DurW-1:0];
	endtask

	// walk the clock through one window so runs start, finish and clear
	task automatic sweep_window(int w);
		int m;
		int stop_at;
		int rain;
		int temp;
		stop_at = win_start[w] + win_len[w] + 5;
		if (stop_at > 2046)
			stop_at = 2046;
		m = int'(win_start[w]) - int'($urandom_range(0, 5));
		if (m < 0)
			m = 0;
		rain = ($urandom_range(1) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 4095);
		temp = ($urandom_range(9) == 0) ? int'(TempNone) : $urandom_range(0, 2047);
		while (m <= stop_at && ticks_sent < phase_goal) begin
			if ($urandom_range(3) == 0) begin
				rain = $urandom_range(0, 4095);
				temp = ($urandom_range(9) == 0) ? int'(TempNone) : $urandom_range(0, 2047);
			end
			offer_tick(make_tick(m, ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 59),
				rain, temp));
			m += $urandom_range(0, 4);
		end
	endtask

	initial begin
		int w;
		board = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: window 0 at 100..130, window 1 saturating at 2047, centre 63 on window 1
		program_windows(16'd100, 16'd30, 16'd2000, 16'd255, 16'hFF10, 16'hFF08, 16'hFD4);
		offer_tick(make_tick(0, 0, 0, 0));
		offer_tick(make_tick(100, 59, 0, TempNone));    // run start, no temperature term
		offer_tick(make_tick(110, 63, 4095, 1023));
		offer_tick(make_tick(130, 1, 0, 0));            // active, stop reached
		offer_tick(make_tick(130, 2, 16, 320));         // start straight into finished
		offer_tick(make_tick(131, 3, 0, 0));
		offer_tick(make_tick(120, 4, 0, 1023));         // hot: negative correction, truncated
		offer_tick(make_tick(481, 5, 0, 0));
		offer_tick(make_tick(100, 6, 16, -1023));       // corrected stop below zero
		offer_tick(make_tick(131, 7, 0, 0));
		offer_tick(make_tick(100, 8, 16, TempNone));
		offer_tick(make_tick(120, 9, 0, 0));            // active into finished
		offer_tick(make_tick(131, 10, 0, 0));
		offer_tick(make_tick(2000, 11, 1, 1008));       // window 1, nominal saturates
		offer_tick(make_tick(2047, 12, 4095, TempNone));
		offer_tick(make_tick(1024, 32, 12'hAAA, 11'h555));
		offer_tick(make_tick(1439, 0, 12'h555, 11'h2AA));
		drain();
		// unmapped index must leave the windows alone
		set_reg(RegSpare, 16'hFFFF);
		cfg_wr_en <= 1'b0;
		offer_tick(make_tick(100, 0, 0, TempNone));
		offer_tick(make_tick(200, 30, 0, 0));

		// random phases: all zero, several random settings, all ones except window 1 (start 0, duration 255)
		for (int p = 0; p < 7; p++) begin
			if (p == 0)
				program_windows('0, '0, '0, '0, '0, '0, '0);
			else if (p == 6)
				program_windows(16'hFFFF, 16'hFFFF, 16'h0000, 16'h00FF, 16'hFFFF, 16'hFFFF,
					16'hFFFF);
			else
				program_windows(start_word(),
					($urandom_range(5) == 0) ? 16'd0 : CfgDataW'($urandom_range(1, 255)),
					start_word(),
					($urandom_range(5) == 0) ? 16'd0 : CfgDataW'($urandom_range(1, 255)),
					CfgDataW'($urandom_range(0, 65535)),
					CfgDataW'(($urandom_range(0, 3) << 8) | $urandom_range(0, 3)),
					CfgDataW'($urandom_range(0, 4095)));
			phase_goal = ticks_sent + PhaseItems;
			while (ticks_sent < phase_goal) begin
				w = $urandom_range(0, 1);
				if (win_len[w] != 0 && $urandom_range(99) < 85)
					sweep_window(w);
				else
					offer_tick(make_tick($urandom_range(0, 2046), $urandom_range(0, 63),
						$urandom_range(0, 4095),
						($urandom_range(19) == 0) ? int'(TempNone) : $urandom_range(0, 2047)));
			end
		end

		drain();
		if (board.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
